### rtl/gsppm_pkg.sv
// ----------------------------------------------------------------------------
// Gas sensor sample to ppm: shared package
// Types, segment tables and fixed constants for the conversion pipeline.
// ----------------------------------------------------------------------------
package gsppm_pkg;

	localparam int GAS_COUNT = 2;
	localparam int SEG_COUNT = 8;
	localparam int GAS_CO = 0;
	localparam int GAS_LPG = 1;

	localparam int QW = 16;
	localparam int PPM_W = 15;
	localparam int FRAC_BITS = 12;
	localparam int C_W = 19;
	localparam int QS_W = 33;
	localparam int RCP_W = 32;
	localparam int RCP_SHIFT = 31;
	localparam int SEL_W = $clog2(SEG_COUNT);

	localparam logic [QW-1:0] R0_RESET = 16'd4096;
	localparam logic [PPM_W-1:0] PPM_MAX = 15'd20000;
	localparam logic [16:0] QS_SCALE = 17'd100000;

	typedef logic [QW-1:0] ratio_t;
	typedef logic [C_W-1:0] coef_t;
	typedef logic [RCP_W-1:0] rcp_t;
	typedef logic [SEL_W-1:0] sel_t;
	typedef logic [PPM_W-1:0] ppm_t;

	typedef struct packed {
		logic valid;
		logic invalid;
	} ctl_t;

	// Lower bound of each segment as the smallest Q4.12 ratio inside it.
	localparam ratio_t SEG_LO [GAS_COUNT][SEG_COUNT] = '{
		'{16'd13312, 16'd12698, 16'd11879, 16'd11469,
		  16'd11264, 16'd10240, 16'd9831, 16'd9216},
		'{16'd2008, 16'd1639, 16'd1516, 16'd1229,
		  16'd1147, 16'd984, 16'd779, 16'd205}
	};

	// Largest Q4.12 ratio inside the first segment, which is closed.
	localparam ratio_t SEG_TOP [GAS_COUNT] = '{16'd15974, 16'd2867};

	// Segment intercepts in units of 1e-5.
	localparam coef_t SEG_C [GAS_COUNT][SEG_COUNT] = '{
		'{19'd433400, 19'd350000, 19'd390000, 19'd307000,
		  19'd301000, 19'd325000, 19'd265000, 19'd255000},
		'{19'd84000, 19'd64000, 19'd52000, 19'd49200,
		  19'd38000, 19'd36000, 19'd33000, 19'd25000}
	};

	// Reciprocals of the segment slopes, rounded up, scaled by 2^31.
	localparam rcp_t SEG_RCP [GAS_COUNT][SEG_COUNT] = '{
		'{32'((64'd2147483648 + 64'd216) / 64'd217),
		  32'((64'd2147483648 + 64'd49) / 64'd50),
		  32'((64'd2147483648 + 64'd99) / 64'd100),
		  32'((64'd2147483648 + 64'd16) / 64'd17),
		  32'((64'd2147483648 + 64'd12) / 64'd13),
		  32'((64'd2147483648 + 64'd24) / 64'd25),
		  32'((64'd2147483648 + 64'd4) / 64'd5),
		  32'((64'd2147483648 + 64'd2) / 64'd3)},
		'{32'((64'd2147483648 + 64'd69) / 64'd70),
		  32'((64'd2147483648 + 64'd29) / 64'd30),
		  32'((64'd2147483648 + 64'd14) / 64'd15),
		  32'((64'd2147483648 + 64'd11) / 64'd12),
		  32'((64'd2147483648 + 64'd4) / 64'd5),
		  32'((64'd2147483648 + 64'd3) / 64'd4),
		  32'((64'd2147483648 + 64'd2) / 64'd3),
		  32'((64'd2147483648 + 64'd0) / 64'd1)}
	};

endpackage

### rtl/gsppm_div.sv
// ----------------------------------------------------------------------------
// Gas sensor sample to ppm: pipelined ratio divider
// Restoring division with one quotient bit per stage and saturation check.
// ----------------------------------------------------------------------------
module gsppm_div import gsppm_pkg::*; #(
	parameter int ADC_BITS = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  ctl_t                    ctl_in,
	input  logic [ADC_BITS+8:0]     numer,
	input  logic [ADC_BITS+15:0]    denom,
	output ctl_t                    ctl_out,
	output ratio_t                  quo
);

	localparam int DW = ADC_BITS + 16;
	localparam int RW = DW + 1;

	logic [RW-1:0] rem_s [QW+1];
	logic [DW-1:0] den_s [QW+1];
	ratio_t        quo_s [QW+1];
	logic          sat_s [QW+1];
	ctl_t          ctl_s [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (adv) begin
			ctl_s[0] <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= RW'(numer);
			den_s[0] <= denom;
			sat_s[0] <= RW'(numer) >= RW'(denom);
			quo_s[0] <= '0;
		end
	end

	for (genvar i = 1; i <= QW; i++) begin : g_stage
		logic [RW-1:0] shifted;
		logic          ge;

		assign shifted = {rem_s[i-1][RW-2:0], 1'b0};
		assign ge = shifted >= {1'b0, den_s[i-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i] <= '0;
			end else if (adv) begin
				ctl_s[i] <= ctl_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i] <= ge ? shifted - {1'b0, den_s[i-1]} : shifted;
				den_s[i] <= den_s[i-1];
				sat_s[i] <= sat_s[i-1];
				quo_s[i] <= {quo_s[i-1][QW-2:0], ge};
			end
		end
	end

	assign ctl_out = ctl_s[QW];
	assign quo = ctl_s[QW].invalid ? '0 : (sat_s[QW] ? '1 : quo_s[QW]);

endmodule

### rtl/gsppm_map.sv
// ----------------------------------------------------------------------------
// Gas sensor sample to ppm: segment mapping
// Maps the Q4.12 ratio through the piecewise linear tables of both gases.
// ----------------------------------------------------------------------------
module gsppm_map import gsppm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   adv,
	input  ctl_t   ctl_in,
	input  ratio_t ratio_in,
	output ctl_t   ctl_out,
	output ratio_t ratio_out,
	output ppm_t   co_out,
	output ppm_t   lpg_out
);

	localparam int PROD_W = C_W + RCP_W;
	localparam int RAW_W = PROD_W - RCP_SHIFT;

	ctl_t                ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	ratio_t              ratio_s1, ratio_s2, ratio_s3, ratio_s4;
	logic [QS_W-1:0]     qs_s1;
	sel_t                sel_s1  [GAS_COUNT];
	logic                hit_s1  [GAS_COUNT];
	coef_t               x_s2    [GAS_COUNT];
	logic                pos_s2  [GAS_COUNT];
	rcp_t                rcp_s2  [GAS_COUNT];
	logic [PROD_W-1:0]   prod_s3 [GAS_COUNT];
	logic                pos_s3  [GAS_COUNT];
	ppm_t                ppm_s4  [GAS_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ratio_s1 <= ratio_in;
			ratio_s2 <= ratio_s1;
			ratio_s3 <= ratio_s2;
			ratio_s4 <= ratio_s3;
			qs_s1 <= QS_W'(ratio_in) * QS_W'(QS_SCALE);
		end
	end

	for (genvar g = 0; g < GAS_COUNT; g++) begin : g_gas
		sel_t              sel;
		logic [QS_W:0]     diff;
		logic [RAW_W-1:0]  raw;
		ppm_t              ppm;

		// Bounds fall with the segment index, so the lowest index whose
		// lower bound is met names the segment.
		always_comb begin
			sel = sel_t'(SEG_COUNT - 1);
			for (int i = SEG_COUNT - 1; i >= 0; i--) begin
				if (ratio_in >= SEG_LO[g][i]) begin
					sel = sel_t'(i);
				end
			end
		end

		assign diff = (QS_W+1)'({SEG_C[g][sel_s1[g]], FRAC_BITS'(0)}) - {1'b0, qs_s1};
		assign raw = prod_s3[g][PROD_W-1:RCP_SHIFT];

		always_comb begin
			if (!pos_s3[g]) begin
				ppm = '0;
			end else if (raw > RAW_W'(PPM_MAX)) begin
				ppm = PPM_MAX;
			end else begin
				ppm = raw[PPM_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sel_s1[g] <= sel;
				hit_s1[g] <= (ratio_in >= SEG_LO[g][SEG_COUNT-1]) && (ratio_in <= SEG_TOP[g]);
				x_s2[g] <= diff[C_W+FRAC_BITS-1:FRAC_BITS];
				pos_s2[g] <= hit_s1[g] && !diff[QS_W] && (diff != '0);
				rcp_s2[g] <= SEG_RCP[g][sel_s1[g]];
				prod_s3[g] <= PROD_W'(x_s2[g]) * PROD_W'(rcp_s2[g]);
				pos_s3[g] <= pos_s2[g];
				ppm_s4[g] <= ppm;
			end
		end
	end

	assign ctl_out = ctl_s4;
	assign ratio_out = ratio_s4;
	assign co_out = ppm_s4[GAS_CO];
	assign lpg_out = ppm_s4[GAS_LPG];

endmodule

### rtl/gas_sensor_sample_to_ppm_unit.sv
// ----------------------------------------------------------------------------
// Gas sensor sample to ppm unit
// Converts converter samples into a resistance ratio and gas concentrations.
// ----------------------------------------------------------------------------
// The sample channel carries one converter reading per transaction on
// sample_valid, sample_stall and adc_sample. The result channel returns one
// transaction per sample on result_valid and result_stall, carrying co_ppm,
// lpg_ppm, resistance_ratio and invalid.
// The clean-air resistance is written through cfg_valid, cfg_ready and
// clean_air_resistance_ratio; cfg_ready is always high, and a write should
// only be made while no sample is in flight.
// A sample passes from acceptance to the result register through a
// register for the product of sample and R0, the divider (a saturation
// check, then one quotient bit per stage) and the segment mapping. A new
// sample can be accepted in every cycle while the pipeline is not held.
// When the receiver stalls a waiting result, the whole pipeline holds and
// sample_stall is raised in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and sets R0 to 1.0 in Q4.12.
// ----------------------------------------------------------------------------
module gas_sensor_sample_to_ppm_unit import gsppm_pkg::*; #(
	parameter int ADC_BITS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  logic [ADC_BITS-1:0]  adc_sample,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [QW-1:0]        clean_air_resistance_ratio,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [PPM_W-1:0]     co_ppm,
	output logic [PPM_W-1:0]     lpg_ppm,
	output logic [QW-1:0]        resistance_ratio,
	output logic                 invalid
);

	localparam int NW = ADC_BITS + 9;
	localparam int DW = ADC_BITS + 16;

	logic                adv;
	ratio_t              r0_q;
	ctl_t                ctl_s1;
	logic [NW-1:0]       numer_s1;
	logic [DW-1:0]       denom_s1;
	logic [ADC_BITS:0]   headroom;
	ctl_t                div_ctl;
	ratio_t              div_quo;
	ctl_t                map_ctl;

	assign adv = !result_valid || !result_stall;
	assign sample_stall = !adv;
	assign cfg_ready = 1'b1;
	assign headroom = {1'b1, {ADC_BITS{1'b0}}} - {1'b0, adc_sample};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r0_q <= R0_RESET;
		end else if (cfg_valid && cfg_ready) begin
			r0_q <= clean_air_resistance_ratio;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid <= sample_valid;
			ctl_s1.invalid <= adc_sample == '0;
		end
	end

	// The dividend (full scale minus sample) times 2^24 has sixteen zero
	// low bits, so only its upper part enters the divider.
	always_ff @(posedge clk) begin
		if (adv) begin
			numer_s1 <= {headroom, 8'b0};
			denom_s1 <= DW'(adc_sample) * DW'(r0_q);
		end
	end

	gsppm_div #(
		.ADC_BITS(ADC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_in  (ctl_s1),
		.numer   (numer_s1),
		.denom   (denom_s1),
		.ctl_out (div_ctl),
		.quo     (div_quo)
	);

	gsppm_map u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.ctl_in    (div_ctl),
		.ratio_in  (div_quo),
		.ctl_out   (map_ctl),
		.ratio_out (resistance_ratio),
		.co_out    (co_ppm),
		.lpg_out   (lpg_ppm)
	);

	assign result_valid = map_ctl.valid;
	assign invalid = map_ctl.invalid;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && invalid |-> resistance_ratio == '0 && co_ppm == '0 && lpg_ppm == '0)
		else $error("invalid result with nonzero fields");

	a_saturated_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && resistance_ratio == '1 |-> co_ppm == '0 && lpg_ppm == '0)
		else $error("saturated ratio with nonzero concentration");

	a_co_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && co_ppm != '0 |->
			resistance_ratio >= SEG_LO[GAS_CO][SEG_COUNT-1] &&
			resistance_ratio <= SEG_TOP[GAS_CO] && co_ppm <= PPM_MAX)
		else $error("carbon monoxide value outside its table range");

	a_lpg_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && lpg_ppm != '0 |->
			resistance_ratio >= SEG_LO[GAS_LPG][SEG_COUNT-1] &&
			resistance_ratio <= SEG_TOP[GAS_LPG] && lpg_ppm <= PPM_MAX)
		else $error("LPG value outside its table range");

endmodule

### tb/gas_sensor_sample_to_ppm_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gas sensor sample to ppm unit testbench
// Streams converter samples through the unit under several clean-air
// resistance settings, predicts the ratio and both gas concentrations for
// every accepted sample, and checks each result transaction in order while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module gas_sensor_sample_to_ppm_unit_tb;
	import gsppm_pkg::*;

	localparam int ADC_BITS = 10;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 200;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int PHASES = 9;

	typedef struct {
		ppm_t   co;
		ppm_t   lpg;
		ratio_t ratio;
		logic   inv;
	} gas_reading_t;

	typedef struct packed {
		logic [19:0] lo;
		logic [19:0] hi;
		logic [19:0] c;
		logic [19:0] k;
	} gas_seg_t;

	function automatic gas_seg_t gas_segment(int gas, int idx);
		gas_seg_t t;
		t = '0;
		if (gas == GAS_CO) begin
			case (idx)
				0: t = '{20'd325000, 20'd390000, 20'd433400, 20'd217};
				1: t = '{20'd310000, 20'd325000, 20'd350000, 20'd50};
				2: t = '{20'd290000, 20'd310000, 20'd390000, 20'd100};
				3: t = '{20'd280000, 20'd290000, 20'd307000, 20'd17};
				4: t = '{20'd275000, 20'd280000, 20'd301000, 20'd13};
				5: t = '{20'd250000, 20'd275000, 20'd325000, 20'd25};
				6: t = '{20'd240000, 20'd250000, 20'd265000, 20'd5};
				default: t = '{20'd225000, 20'd240000, 20'd255000, 20'd3};
			endcase
		end else begin
			case (idx)
				0: t = '{20'd49000, 20'd70000, 20'd84000, 20'd70};
				1: t = '{20'd40000, 20'd49000, 20'd64000, 20'd30};
				2: t = '{20'd37000, 20'd40000, 20'd52000, 20'd15};
				3: t = '{20'd30000, 20'd37000, 20'd49200, 20'd12};
				4: t = '{20'd28000, 20'd30000, 20'd38000, 20'd5};
				5: t = '{20'd24000, 20'd28000, 20'd36000, 20'd4};
				6: t = '{20'd19000, 20'd24000, 20'd33000, 20'd3};
				default: t = '{20'd5000, 20'd19000, 20'd25000, 20'd1};
			endcase
		end
		return t;
	endfunction

	class ppm_scoreboard;
		ratio_t       r0;
		gas_reading_t pending[$];
		int           errors;

		function new();
			r0 = R0_RESET;
			errors = 0;
		endfunction

		function ppm_t gas_ppm(int gas, ratio_t q);
			longint unsigned scaled;
			longint unsigned lo;
			longint unsigned hi;
			longint unsigned top;
			longint unsigned ppm;
			gas_seg_t seg;
			scaled = longint'(q) * 100000;
			for (int i = 0; i < SEG_COUNT; i++) begin
				seg = gas_segment(gas, i);
				lo = longint'(seg.lo) * 4096;
				hi = longint'(seg.hi) * 4096;
				if (scaled >= lo && (i == 0 ? scaled <= hi : scaled < hi)) begin
					top = longint'(seg.c) * 4096;
					if (scaled >= top)
						return '0;
					ppm = (top - scaled) / (longint'(seg.k) * 4096);
					return (ppm > PPM_MAX) ? PPM_MAX : ppm_t'(ppm);
				end
			end
			return '0;
		endfunction

		function void note_sample(logic [ADC_BITS-1:0] s);
			gas_reading_t exp_r;
			longint unsigned num;
			longint unsigned den;
			longint unsigned q;
			exp_r = '{co: '0, lpg: '0, ratio: '0, inv: 1'b0};
			if (s == 0) begin
				exp_r.inv = 1'b1;
			end else begin
				if (r0 == 0) begin
					q = 65535;
				end else begin
					num = ((longint'(1) << ADC_BITS) - longint'(s)) << 24;
					den = longint'(s) * longint'(r0);
					q = num / den;
					if (q > 65535)
						q = 65535;
				end
				exp_r.ratio = ratio_t'(q);
				exp_r.co = gas_ppm(GAS_CO, exp_r.ratio);
				exp_r.lpg = gas_ppm(GAS_LPG, exp_r.ratio);
			end
			pending.push_back(exp_r);
		endfunction

		function void check_result(gas_reading_t got);
			gas_reading_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result transaction, ratio %0d", $realtime,
					got.ratio);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.co !== exp_r.co) begin
				$display("%0t: co_ppm expected %0d actual %0d", $realtime, exp_r.co,
					got.co);
				errors++;
			end
			if (got.lpg !== exp_r.lpg) begin
				$display("%0t: lpg_ppm expected %0d actual %0d", $realtime, exp_r.lpg,
					got.lpg);
				errors++;
			end
			if (got.ratio !== exp_r.ratio) begin
				$display("%0t: resistance_ratio expected %0d actual %0d", $realtime,
					exp_r.ratio, got.ratio);
				errors++;
			end
			if (got.inv !== exp_r.inv) begin
				$display("%0t: invalid expected %0d actual %0d", $realtime, exp_r.inv,
					got.inv);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                sample_valid;
	logic                sample_stall;
	logic [ADC_BITS-1:0] adc_sample;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [QW-1:0]       clean_air_resistance_ratio;
	logic                result_valid;
	logic                result_stall;
	logic [PPM_W-1:0]    co_ppm;
	logic [PPM_W-1:0]    lpg_ppm;
	logic [QW-1:0]       resistance_ratio;
	logic                invalid;

	ppm_scoreboard sb;
	bit            idle_on;
	bit            hold_req;
	int            quiet_cycles;

	gas_sensor_sample_to_ppm_unit #(
		.ADC_BITS(ADC_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.adc_sample(adc_sample),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.clean_air_resistance_ratio(clean_air_resistance_ratio),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.co_ppm(co_ppm),
		.lpg_ppm(lpg_ppm),
		.resistance_ratio(resistance_ratio),
		.invalid(invalid)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			quiet_cycles++;
			if (sample_valid && !sample_stall) begin
				sb.note_sample(adc_sample);
				quiet_cycles = 0;
			end
			if (result_valid && !result_stall) begin
				sb.check_result('{co: co_ppm, lpg: lpg_ppm, ratio: resistance_ratio,
					inv: invalid});
				quiet_cycles = 0;
			end
			if (cfg_valid && cfg_ready)
				quiet_cycles = 0;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		int hold_left;
		hold_left = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= idle_on && ($urandom_range(0, 99) < 12);
			end
		end
	end

	task automatic send_sample(input logic [ADC_BITS-1:0] s);
		while (idle_on && $urandom_range(0, 99) < 12) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		adc_sample <= s;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		sample_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_r0(input ratio_t v);
		wait_drained();
		cfg_valid <= 1'b1;
		clean_air_resistance_ratio <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.r0 = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [ADC_BITS-1:0] pick_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return '0;
		if (r < 8)
			return ($urandom_range(0, 1) != 0) ? '1 : ADC_BITS'(1);
		return ADC_BITS'($urandom_range(1, (1 << ADC_BITS) - 1));
	endfunction

	initial begin
		ratio_t setting;
		sb = new();
		idle_on = 1'b1;
		hold_req = 1'b0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		adc_sample = '0;
		cfg_valid = 1'b0;
		clean_air_resistance_ratio = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed samples at the reset value of R0: zero, the extremes,
		// alternating bit patterns and points inside both tables.
		send_sample('0);
		send_sample(ADC_BITS'(1));
		send_sample(ADC_BITS'(2));
		send_sample('1);
		send_sample(ADC_BITS'(1022));
		send_sample(ADC_BITS'(512));
		send_sample(ADC_BITS'(511));
		send_sample(ADC_BITS'(341));
		send_sample(ADC_BITS'(682));
		send_sample(ADC_BITS'(215));
		send_sample(ADC_BITS'(240));
		send_sample(ADC_BITS'(260));
		send_sample(ADC_BITS'(900));
		send_sample(ADC_BITS'(975));
		send_sample(ADC_BITS'(1000));

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				1: setting = '0;
				2: setting = ratio_t'(1);
				3: setting = '1;
				4: setting = ratio_t'(2048);
				5: setting = ratio_t'(8192);
				8: setting = R0_RESET;
				default: setting = ratio_t'($urandom_range(1, 65535));
			endcase
			if (p != 0)
				write_r0(setting);
			idle_on = (p != 4);
			if (p == 5)
				hold_req = 1'b1;
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				send_sample(pick_sample());
		end

		wait_drained();
		repeat (30) @(posedge clk);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
rtl/gsppm_pkg.sv
rtl/gsppm_div.sv
rtl/gsppm_map.sv
rtl/gas_sensor_sample_to_ppm_unit.sv
tb/gas_sensor_sample_to_ppm_unit_tb.sv
